>>> sv/sclru_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sector cache LRU directory.
// No dependencies; used by the controller, datapath and top level.
package sclru_pkg;

   localparam int DEF_ENTRIES = 64;

   localparam int DRIVE_W  = 8;
   localparam int LBA_W    = 32;
   localparam int TARGET_W = 6;
   localparam int INDEX_W  = 6;
   localparam int CLEAR_W  = 7;
   localparam int KIND_W   = 2;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INVAL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SCAN,
      CMD_DECIDE,
      CMD_PROMOTE,
      CMD_COMMIT,
      CMD_RESULT
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              scan_done;
      logic              rsp_free;
   } status_type;

endpackage

>>> sv/sclru_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sclru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/sclru_ctrl.sv
`timescale 1ns / 1ps
// Controller of the sector cache LRU directory: sequences scan, promote and result.
// Depends on sclru_pkg.
module sclru_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  sclru_pkg::status_type status,
   output sclru_pkg::cmd_type    cmd
);
   import sclru_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_PROMOTE,
      ST_COMMIT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd      = CMD_LOAD;
               ready_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd = CMD_SCAN;
            if (status.kind != KIND_ACCESS && status.kind != KIND_INVAL) begin
               state_in = ST_DONE;
            end else if (status.scan_done) begin
               state_in = (status.kind == KIND_ACCESS) ? ST_DECIDE : ST_DONE;
            end
         end
         ST_DECIDE: begin
            cmd      = CMD_DECIDE;
            state_in = ST_PROMOTE;
         end
         ST_PROMOTE: begin
            cmd = CMD_PROMOTE;
            if (status.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd      = CMD_COMMIT;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd      = CMD_RESULT;
               ready_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
endmodule

>>> sv/sclru_dp.sv
`timescale 1ns / 1ps
// Datapath of the sector cache LRU directory: tag/rank RAM, valid bits, result register.
// Depends on sclru_pkg and sclru_ram.
module sclru_dp #(
   parameter int ENTRIES = sclru_pkg::DEF_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sclru_pkg::cmd_type                  cmd,
   output sclru_pkg::status_type               status,
   input  logic [sclru_pkg::KIND_W-1:0]        req_tuser,
   input  logic [sclru_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sclru_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import sclru_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int UW = $clog2(ENTRIES + 1);
   localparam int WW = IW + LBA_W + DRIVE_W;

   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [DRIVE_W-1:0]  drive_ff, drive_in;
   logic [LBA_W-1:0]    lba_ff, lba_in;
   logic [TARGET_W-1:0] tgt_ff, tgt_in;
   logic [UW-1:0]       cnt_ff, cnt_in;
   logic [UW-1:0]       used_ff, used_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [IW-1:0]       rd_idx_ff, rd_idx_in;
   logic                found_ff, found_in;
   logic [IW-1:0]       slot_ff, slot_in;
   logic [UW-1:0]       old_rank_ff, old_rank_in;
   logic [IW-1:0]       lru_slot_ff, lru_slot_in;
   logic [DRIVE_W-1:0]  lru_drive_ff, lru_drive_in;
   logic [LBA_W-1:0]    lru_lba_ff, lru_lba_in;
   logic                vvalid_ff, vvalid_in;
   logic [DRIVE_W-1:0]  vdrive_ff, vdrive_in;
   logic [LBA_W-1:0]    vlba_ff, vlba_in;
   logic [UW-1:0]       cleared_ff, cleared_in;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [WW-1:0] wr_data;
   logic [WW-1:0] rd_data;
   logic [IW-1:0] rd_rank;
   logic [LBA_W-1:0]   rd_lba;
   logic [DRIVE_W-1:0] rd_drive;
   logic          issue;
   logic          drop_ok;
   logic [IW-1:0] tgt_idx;
   logic          is_hit;
   logic [CLEAR_W-1:0] clr_out;

   sclru_ram #(.WIDTH(WW), .DEPTH(ENTRIES)) u_tags (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   assign rd_drive = rd_data[DRIVE_W-1:0];
   assign rd_lba   = rd_data[DRIVE_W+LBA_W-1:DRIVE_W];
   assign rd_rank  = rd_data[WW-1:DRIVE_W+LBA_W];
   assign issue    = (cmd == CMD_SCAN || cmd == CMD_PROMOTE) && (cnt_ff < used_ff);
   assign tgt_idx  = IW'(tgt_ff);
   assign drop_ok  = (32'(tgt_ff) < 32'(used_ff)) && (32'(tgt_ff) < 32'(ENTRIES))
                     && valid_ff[tgt_idx];
   assign is_hit   = (kind_ff == KIND_ACCESS) && found_ff;

   always_comb begin
      if (kind_ff == KIND_INVAL) begin
         clr_out = CLEAR_W'(cleared_ff);
      end else if (kind_ff == KIND_DROP && drop_ok) begin
         clr_out = CLEAR_W'(1);
      end else begin
         clr_out = '0;
      end
   end

   always_comb begin
      kind_in      = kind_ff;
      drive_in     = drive_ff;
      lba_in       = lba_ff;
      tgt_in       = tgt_ff;
      cnt_in       = cnt_ff;
      used_in      = used_ff;
      rd_pend_in   = rd_pend_ff;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      old_rank_in  = old_rank_ff;
      lru_slot_in  = lru_slot_ff;
      lru_drive_in = lru_drive_ff;
      lru_lba_in   = lru_lba_ff;
      vvalid_in    = vvalid_ff;
      vdrive_in    = vdrive_ff;
      vlba_in      = vlba_ff;
      cleared_in   = cleared_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = rd_idx_ff;
      wr_data      = {rd_rank + IW'(1), rd_lba, rd_drive};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd == CMD_SCAN || cmd == CMD_PROMOTE) begin
         rd_pend_in = issue;
         rd_idx_in  = cnt_ff[IW-1:0];
         if (issue) begin
            cnt_in = cnt_ff + UW'(1);
         end
      end

      unique case (cmd)
         CMD_LOAD: begin
            kind_in    = req_tuser;
            drive_in   = req_tdata[DRIVE_W-1:0];
            lba_in     = req_tdata[DRIVE_W+LBA_W-1:DRIVE_W];
            tgt_in     = req_tdata[DRIVE_W+LBA_W+TARGET_W-1:DRIVE_W+LBA_W];
            cnt_in     = '0;
            rd_pend_in = 1'b0;
            found_in   = 1'b0;
            slot_in    = '0;
            lru_slot_in = '0;
            vvalid_in  = 1'b0;
            vdrive_in  = '0;
            vlba_in    = '0;
            cleared_in = '0;
         end
         CMD_SCAN: begin
            if (rd_pend_ff) begin
               if (kind_ff == KIND_ACCESS) begin
                  if (valid_ff[rd_idx_ff] && rd_drive == drive_ff && rd_lba == lba_ff
                      && !found_ff) begin
                     found_in    = 1'b1;
                     slot_in     = rd_idx_ff;
                     old_rank_in = UW'(rd_rank);
                  end
                  if (UW'(rd_rank) == used_ff - UW'(1)) begin
                     lru_slot_in  = rd_idx_ff;
                     lru_drive_in = rd_drive;
                     lru_lba_in   = rd_lba;
                  end
               end else if (kind_ff == KIND_INVAL) begin
                  if (valid_ff[rd_idx_ff] && rd_drive == drive_ff) begin
                     valid_in[rd_idx_ff] = 1'b0;
                     cleared_in          = cleared_ff + UW'(1);
                  end
               end
            end
         end
         CMD_DECIDE: begin
            cnt_in     = '0;
            rd_pend_in = 1'b0;
            if (!found_ff) begin
               if (used_ff < UW'(ENTRIES)) begin
                  slot_in     = used_ff[IW-1:0];
                  old_rank_in = used_ff + UW'(1);
                  used_in     = used_ff + UW'(1);
               end else begin
                  slot_in     = lru_slot_ff;
                  old_rank_in = used_ff - UW'(1);
                  if (valid_ff[lru_slot_ff]) begin
                     vvalid_in = 1'b1;
                     vdrive_in = lru_drive_ff;
                     vlba_in   = lru_lba_ff;
                  end
               end
            end
         end
         CMD_PROMOTE: begin
            if (rd_pend_ff && rd_idx_ff != slot_ff && UW'(rd_rank) < old_rank_ff) begin
               wr_en = 1'b1;
            end
         end
         CMD_COMMIT: begin
            wr_en             = 1'b1;
            wr_addr           = slot_ff;
            wr_data           = {IW'(0), lba_ff, drive_ff};
            valid_in[slot_ff] = 1'b1;
         end
         CMD_RESULT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {1'b0, clr_out, vlba_ff, vdrive_ff, vvalid_ff,
                            (kind_ff == KIND_ACCESS) ? INDEX_W'(slot_ff) : INDEX_W'(0),
                            is_hit};
            if (kind_ff == KIND_DROP && drop_ok) begin
               valid_in[tgt_idx] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
      end
      kind_ff      <= kind_in;
      drive_ff     <= drive_in;
      lba_ff       <= lba_in;
      tgt_ff       <= tgt_in;
      rd_idx_ff    <= rd_idx_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      old_rank_ff  <= old_rank_in;
      lru_slot_ff  <= lru_slot_in;
      lru_drive_ff <= lru_drive_in;
      lru_lba_ff   <= lru_lba_in;
      vvalid_ff    <= vvalid_in;
      vdrive_ff    <= vdrive_in;
      vlba_ff      <= vlba_in;
      cleared_ff   <= cleared_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign status.kind      = kind_ff;
   assign status.scan_done = (cnt_ff >= used_ff) && !rd_pend_ff;
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(ENTRIES))
      else $error("slot count beyond capacity");
   a_valid_used: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) <= 32'(used_ff))
      else $error("more valid entries than used slots");
   a_commit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_COMMIT |-> 32'(slot_ff) < 32'(used_ff))
      else $error("commit to unused slot");
endmodule

>>> sv/sector_cache_lru_directory_unit.sv
`timescale 1ns / 1ps
// Tag directory of a fully associative sector cache with true LRU replacement.
// An access scans all used slots through one RAM read port (one slot per cycle), then
// a second pass rewrites the LRU ranks; invalidate-drive makes only the scan, and
// drop-entry and unknown kinds skip the scan. One transaction is worked on at a time;
// a new one is taken while the last result waits in the output register. Depends on
// sclru_pkg, sclru_ctrl, sclru_dp, sclru_ram.
module sector_cache_lru_directory_unit #(
   parameter int ENTRIES = sclru_pkg::DEF_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // kind
   input  logic [sclru_pkg::KIND_W-1:0]      req_tuser,
   // drive, lba, target_entry
   input  logic [sclru_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hit, entry_index, victim_valid, victim_drive, victim_lba, cleared_count
   output logic [sclru_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import sclru_pkg::*;

   cmd_type    cmd;
   status_type status;

   sclru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sclru_dp #(.ENTRIES(ENTRIES)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of sector_cache_lru_directory_unit: directory predictor,
// scoreboard class and stream drivers. Depends on sclru_pkg and the RTL of the unit.
module tb_top;
   import sclru_pkg::*;

   localparam int NSLOT = DEF_ENTRIES;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [6:0]  cleared;
      logic [31:0] vlba;
      logic [7:0]  vdrive;
      logic        vvalid;
      logic [5:0]  idx;
      logic        hit;
   } lookup_type;

   class dir_scoreboard;
      logic [7:0]  tag_drive [NSLOT];
      logic [31:0] tag_lba [NSLOT];
      bit          valid [NSLOT];
      int          rank [NSLOT];
      int          used;
      lookup_type  pending[$];
      int          errors;
      int          matched;

      function void clear();
         foreach (valid[i]) begin
            valid[i] = 0;
            rank[i] = 0;
         end
         used = 0;
         errors = 0;
         matched = 0;
      endfunction

      function void bump(int s, int old_rank);
         for (int i = 0; i < used; i++)
            if (i != s && rank[i] < old_rank) rank[i]++;
         rank[s] = 0;
      endfunction

      function void note_request(logic [1:0] kind, logic [7:0] drv, logic [31:0] lba,
                                 logic [5:0] tgt);
         lookup_type r;
         int s;
         bit found;
         r = '0;
         s = 0;
         found = 0;
         if (kind == KIND_ACCESS) begin
            for (int i = 0; i < used; i++)
               if (!found && valid[i] && tag_drive[i] == drv && tag_lba[i] == lba) begin
                  found = 1;
                  s = i;
               end
            if (found) begin
               r.hit = 1;
               bump(s, rank[s]);
            end else if (used < NSLOT) begin
               s = used;
               used++;
               tag_drive[s] = drv;
               tag_lba[s] = lba;
               valid[s] = 1;
               bump(s, used);
            end else begin
               for (int i = NSLOT - 1; i >= 0; i--)
                  if (rank[i] == used - 1) s = i;
               if (valid[s]) begin
                  r.vvalid = 1;
                  r.vdrive = tag_drive[s];
                  r.vlba = tag_lba[s];
               end
               tag_drive[s] = drv;
               tag_lba[s] = lba;
               valid[s] = 1;
               bump(s, rank[s]);
            end
            r.idx = s[5:0];
         end else if (kind == KIND_INVAL) begin
            for (int i = 0; i < used; i++)
               if (valid[i] && tag_drive[i] == drv) begin
                  valid[i] = 0;
                  r.cleared++;
               end
         end else if (kind == KIND_DROP) begin
            if (tgt < used && valid[tgt]) begin
               valid[tgt] = 0;
               r.cleared = 1;
            end
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] data);
         lookup_type got, exp;
         got = lookup_type'(data[$bits(lookup_type)-1:0]);
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", data);
            return;
         end
         exp = pending.pop_front();
         if (got !== exp || data[RSP_TDATA_W-1:$bits(lookup_type)] !== '0) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: exp hit=%0d idx=%0d vv=%0d vd=%h vl=%h clr=%0d",
                         " | got hit=%0d idx=%0d vv=%0d vd=%h vl=%h clr=%0d pad=%h"},
                  exp.hit, exp.idx, exp.vvalid, exp.vdrive, exp.vlba, exp.cleared,
                  got.hit, got.idx, got.vvalid, got.vdrive, got.vlba, got.cleared,
                  data[RSP_TDATA_W-1:$bits(lookup_type)]);
         end else begin
            matched++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [KIND_W-1:0]      req_tuser;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   dir_scoreboard dir_sb;
   bit            calm;
   int            n_access;
   int            n_inval;
   int            n_drop;
   int            n_odd;

   sector_cache_lru_directory_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

   // result side: random stall, check every transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) dir_sb.check_result(rsp_tdata);
         rsp_tready <= calm || ($urandom_range(99) >= 35);
      end
   end

   task automatic send(logic [1:0] kind, logic [7:0] drv, logic [31:0] lba, logic [5:0] tgt);
      while (!calm && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {tgt, lba, drv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      dir_sb.note_request(kind, drv, lba, tgt);
      case (kind)
         KIND_ACCESS: n_access++;
         KIND_INVAL:  n_inval++;
         KIND_DROP:   n_drop++;
         default:     n_odd++;
      endcase
   endtask

   task automatic random_item(int pool_lba);
      int pick;
      logic [7:0] drv;
      logic [31:0] lba;
      pick = $urandom_range(99);
      drv = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      lba = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(pool_lba));
      if (pick < 80) send(KIND_ACCESS, drv, lba, 6'($urandom));
      else if (pick < 86) send(KIND_INVAL, drv, $urandom, 6'($urandom));
      else if (pick < 97) send(KIND_DROP, 8'($urandom), $urandom, 6'($urandom));
      else send(KIND_UNUSED, 8'($urandom), $urandom, 6'($urandom));
   endtask

   initial begin
      dir_sb = new();
      dir_sb.clear();
      calm = 0;
      n_access = 0;
      n_inval = 0;
      n_drop = 0;
      n_odd = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, drop before use, unknown kind, hit, invalidate
      send(KIND_DROP, 8'h00, 32'h0, 6'd0);
      send(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
      send(KIND_ACCESS, 8'h00, 32'h0, 6'd0);
      send(KIND_ACCESS, 8'hFF, 32'hFFFF_FFFF, 6'd63);
      send(KIND_ACCESS, 8'h00, 32'h0, 6'd0);
      send(KIND_ACCESS, 8'hFF, 32'h0, 6'd0);
      send(KIND_DROP, 8'h00, 32'h0, 6'd63);
      send(KIND_DROP, 8'h00, 32'h0, 6'd1);
      send(KIND_DROP, 8'h00, 32'h0, 6'd1);
      send(KIND_ACCESS, 8'hFF, 32'hFFFF_FFFF, 6'd0);
      send(KIND_INVAL, 8'hFF, 32'h0, 6'd0);
      send(KIND_INVAL, 8'h55, 32'h0, 6'd0);
      send(KIND_ACCESS, 8'hAA, 32'h5555_5555, 6'h2A);
      send(KIND_ACCESS, 8'h55, 32'hAAAA_AAAA, 6'h15);

      // fill the directory, then evict valid and invalid tails
      for (int i = 0; i < 70; i++) send(KIND_ACCESS, 8'd7, 32'(i), 6'd0);
      send(KIND_DROP, 8'h0, 32'h0, 6'd9);
      send(KIND_INVAL, 8'd7, 32'h0, 6'd0);
      for (int i = 0; i < 8; i++) send(KIND_ACCESS, 8'd3, 32'(i), 6'd0);

      for (int i = 0; i < 1600; i++) begin
         calm = (i >= 600 && i < 900);
         random_item((i < 800) ? 40 : 120);
      end
      calm = 0;
      req_tvalid <= 1'b0;

      while (dir_sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Covered %0d accesses, %0d drive invalidations, %0d drops, %0d unknown kinds;",
               n_access, n_inval, n_drop, n_odd);
      $display("%0d results matched, %0d mismatches.", dir_sb.matched, dir_sb.errors);
      if (dir_sb.errors == 0 && dir_sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

>>> filelist.f
sv/sclru_pkg.sv
sv/sclru_ram.sv
sv/sclru_ctrl.sv
sv/sclru_dp.sv
sv/sector_cache_lru_directory_unit.sv
tb/tb_top.sv
